// File: rtl/core/pma_pkg.sv
// ---------------------------------------------------------------------------
// pma_pkg
// Shared widths, defaults and types of the prefilled moving average core.
// ---------------------------------------------------------------------------
`default_nettype none

package pma_pkg;

  // fixed field widths of the sample and result beats
  localparam int unsigned SampleW  = 16;
  localparam int unsigned AverageW = 16;
  localparam logic [AverageW-1:0] AverageMax = '1;

  // default configuration of the core
  localparam int unsigned DepthDef      = 16;
  localparam int unsigned ShiftDef      = 4;
  localparam int unsigned SampleBitsDef = 16;

  // control that every window cell sees
  typedef struct packed {
    logic load;   // an accepted beat moves the window
    logic fill;   // prefill: every cell takes the new sample
  } pma_cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/pma_cell.sv
// ---------------------------------------------------------------------------
// pma_cell
// One window entry: takes its left neighbor's sample on every accepted beat,
// or the new sample itself when the window is prefilled.
// ---------------------------------------------------------------------------
`default_nettype none

module pma_cell #(
  parameter int unsigned SAMPLE_BITS = pma_pkg::SampleBitsDef
) (
  input  wire                          clk,
  input  wire pma_pkg::pma_cell_ctrl_t ctrl,
  input  wire logic [SAMPLE_BITS-1:0]  fill_data,
  input  wire logic [SAMPLE_BITS-1:0]  prev_data,
  output logic [SAMPLE_BITS-1:0]       data_r
);
  import pma_pkg::*;

  logic [SAMPLE_BITS-1:0] data_nxt;

  // shift from the neighbor or prefill
  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = ctrl.fill ? fill_data : prev_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/pma_accum.sv
// ---------------------------------------------------------------------------
// pma_accum
// Running sum and first-sample flag; forms the saturated average of a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module pma_accum #(
  parameter int unsigned DEPTH       = pma_pkg::DepthDef,
  parameter int unsigned SHIFT       = pma_pkg::ShiftDef,
  parameter int unsigned SAMPLE_BITS = pma_pkg::SampleBitsDef
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                accept,
  input  wire                                restart,
  input  wire logic [SAMPLE_BITS-1:0]        sample,
  input  wire logic [SAMPLE_BITS-1:0]        oldest,
  output pma_pkg::pma_cell_ctrl_t            ctrl,
  output logic [pma_pkg::AverageW-1:0]       average
);
  import pma_pkg::*;

  localparam int unsigned SumW = SAMPLE_BITS + $clog2(DEPTH);

  logic            first_r;
  logic            first_nxt;
  logic [SumW-1:0] sum_r;
  logic [SumW-1:0] sum_nxt;
  logic [SumW-1:0] shifted;
  logic            prefill;

  assign prefill = first_r | restart;

  // window control for the cells
  assign ctrl.load = accept;
  assign ctrl.fill = prefill;

  // sum update: prefill loads sample times depth, else drop oldest, add new
  always_comb begin
    sum_nxt   = sum_r;
    first_nxt = first_r;
    if (accept) begin
      first_nxt = 1'b0;
      if (prefill) begin
        sum_nxt = SumW'(sample) * SumW'(DEPTH);
      end else begin
        sum_nxt = sum_r - SumW'(oldest) + SumW'(sample);
      end
    end
  end

  // beat result: sample itself on prefill, else saturated to the field width
  assign shifted = sum_nxt >> SHIFT;
  always_comb begin
    if (prefill) begin
      average = AverageW'(sample);
    end else if (shifted > SumW'(AverageMax)) begin
      average = AverageMax;
    end else begin
      average = AverageW'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      sum_r   <= '0;
    end else begin
      first_r <= first_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pma_out_skid.sv
// ---------------------------------------------------------------------------
// pma_out_skid
// Output register with a skid entry, so a new beat is taken while the
// previous result waits on a stalled receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module pma_out_skid #(
  parameter int unsigned W = pma_pkg::AverageW
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire logic [W-1:0]   push_data,
  output logic                full,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [W-1:0]        out_data
);
  import pma_pkg::*;

  logic         main_v_r, main_v_nxt;
  logic [W-1:0] main_d_r, main_d_nxt;
  logic         skid_v_r, skid_v_nxt;
  logic [W-1:0] skid_d_r, skid_d_nxt;
  logic         main_free;

  assign main_free = !main_v_r || !out_stall;

  // main refills from the skid first, new beats park in the skid on a stall
  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (main_free) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

`default_nettype wire

// File: rtl/core/prefilled_moving_average_core.sv
// Results are registered in the output buffer, or its skid entry on a stall.
// Throughput: one sample beat per cycle while the skid is empty; the window
// is a shift chain of cells; the sum takes one subtract, one add per beat.
// Reset (synchronous, active low) clears the output buffer, the sum and sets
// the first-sample flag; window cells are not cleared, since the first beat
// after reset prefills every cell.
// ---------------------------------------------------------------------------
// prefilled_moving_average_core
// Sliding-window average over the last DEPTH samples, prefilled on the first
// beat after reset or on restart.
// ---------------------------------------------------------------------------
`default_nettype none

module prefilled_moving_average_core #(
  parameter int unsigned DEPTH       = pma_pkg::DepthDef,
  parameter int unsigned SHIFT       = pma_pkg::ShiftDef,
  parameter int unsigned SAMPLE_BITS = pma_pkg::SampleBitsDef
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire logic [pma_pkg::SampleW-1:0]   in_sample,
  input  wire                                in_restart,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [pma_pkg::AverageW-1:0]       out_average
);
  import pma_pkg::*;

  logic                   accept;
  logic                   full;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] win [DEPTH];
  logic [AverageW-1:0]    average;
  pma_cell_ctrl_t         ctrl;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // only the low SAMPLE_BITS bits of the sample count
  assign sample = SAMPLE_BITS'({16'd0, in_sample});

  // window chain: cell zero takes the new sample, the last holds the oldest
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      pma_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .fill_data (sample),
        .prev_data (sample),
        .data_r    (win[i])
      );
    end else begin : g_body
      pma_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .fill_data (sample),
        .prev_data (win[i-1]),
        .data_r    (win[i])
      );
    end
  end

  // running sum and average
  pma_accum #(
    .DEPTH       (DEPTH),
    .SHIFT       (SHIFT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .restart (in_restart),
    .sample  (sample),
    .oldest  (win[DEPTH-1]),
    .ctrl    (ctrl),
    .average (average)
  );

  // result buffer
  pma_out_skid #(.W(AverageW)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (average),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_average)
  );

endmodule

`default_nettype wire

// File: rtl/core/pma_checker.sv
// ---------------------------------------------------------------------------
// pma_checker
// Port-level checks of the prefilled moving average core, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module pma_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire logic [pma_pkg::SampleW-1:0]   in_sample,
  input  wire                                in_restart,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire logic [pma_pkg::AverageW-1:0]  out_average
);
  import pma_pkg::*;

  // input side only backs up when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // input stall only starts after a stalled result beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output stall");

  // a taken beat reaches an empty output in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> out_valid)
    else $error("result beat missing after one cycle");

  // a restart beat passes its sample through
  a_restart_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid && in_restart)
      |=> (out_average == $past(in_sample)))
    else $error("restart beat did not pass its sample");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_average)))
    else $error("stalled result beat changed");

endmodule

bind prefilled_moving_average_core pma_checker u_pma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_sample   (in_sample),
  .in_restart  (in_restart),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_average (out_average)
);

`default_nettype wire
